### rtl/mqb_pkg.sv
`default_nettype none
package mqb_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BASE_PAGES  = 3'd0;
    localparam logic [2:0] CFG_PRIO_STEP   = 3'd1;
    localparam logic [2:0] CFG_FAULT_THR   = 3'd2;
    localparam logic [2:0] CFG_LOW_LEVEL   = 3'd3;
    localparam logic [2:0] CFG_ENTRY_CAP   = 3'd4;
    localparam logic [2:0] CFG_TOTAL_LIMIT = 3'd5;

    // Actions.
    localparam logic [1:0] ACT_REGISTER   = 2'd0;
    localparam logic [1:0] ACT_UPDATE     = 2'd1;
    localparam logic [1:0] ACT_DEREGISTER = 2'd2;
    localparam logic [1:0] ACT_REBALANCE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [7:0]  INITIAL_SCORE = 8'd50;
    localparam logic [23:0] TOTAL_MAX     = 24'hFFFFFF;

    // floor(y / 3) = (y * DIV3_M) >> DIV3_S for y below 2^19.
    localparam logic [19:0] DIV3_M = 20'd174763;
    localparam int          DIV3_S = 19;
    // floor(s / 10) = (s * DIV10_M) >> DIV10_S for s below 2^14.
    localparam logic [11:0] DIV10_M = 12'd3277;
    localparam int          DIV10_S = 15;

    typedef struct packed {
        logic        active;
        logic [7:0]  score;
        logic [31:0] faults;
        logic [16:0] pages;
        logic [7:0]  prio;
        logic [31:0] id;
    } t_row;

endpackage
`default_nettype wire

### rtl/memory_quota_balancer.sv
`default_nettype none
// Memory quota balancer.
// Input transactions arrive on the s_ channel: s_tuser carries the action
// (register, update, deregister, rebalance), s_tdata the process fields.
// Every input transaction yields exactly one result transaction on the m_
// channel: m_tuser carries the status, m_tdata the page total, the number of
// quotas changed by a rebalance and the number of table slots used.
// The block handles one item at a time; s_tready is high only while idle.
// Update and deregister walk the table slot by slot with the one table read
// port. Rebalance walks the used slots twice through one quota unit; on the
// second pass each active entry also goes through the bit-serial divider and
// the floor when the quota sum exceeds the page budget. The result sits in
// an output register; the next item is taken while it waits, and a stalled
// receiver holds the block before its next result only. Reset clears the
// slot count, the page total and the output valid flag, and loads the
// configuration registers with their defaults. Configuration writes take
// effect at once; the user must make them only while the block is idle,
// as the block itself does not enforce this.
module memory_quota_balancer #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_addr,
    input  wire logic [20:0]   i_cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // proc_id[31:0], prio_level[39:32], start_pages[56:40],
    // fault_count[88:57], score_sample[96:89], zero pad[103:97]
    input  wire logic [103:0]  s_tdata,
    // action[1:0]
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // total_pages[23:0], adjusted_count[31:24], used_slots[39:32]
    output logic [39:0]        m_tdata,
    // status[1:0]
    output logic [1:0]         m_tuser
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W  = 17 + CW;
    localparam int CMP_W  = (SUM_W > 21) ? SUM_W : 21;
    localparam int PROD_W = 38;
    localparam int DCW    = $clog2(PROD_W + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_REG    = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_UPD1   = 4'd4;
    localparam logic [3:0] S_UPD2   = 4'd5;
    localparam logic [3:0] S_RB_RD  = 4'd6;
    localparam logic [3:0] S_Q1     = 4'd7;
    localparam logic [3:0] S_Q2     = 4'd8;
    localparam logic [3:0] S_Q3     = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_FLOOR  = 4'd11;
    localparam logic [3:0] S_APPLY  = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    mqb_pkg::t_row r_mem [TABLE_DEPTH];
    mqb_pkg::t_row r_rd;

    logic [3:0]        r_state;
    logic [13:0]       r_min;
    logic [6:0]        r_pstep;
    logic [15:0]       r_fthr;
    logic [7:0]        r_low;
    logic [16:0]       r_cap;
    logic [20:0]       r_limit;

    logic [1:0]        r_act;
    logic [31:0]       r_id;
    logic [7:0]        r_prio;
    logic [16:0]       r_start;
    logic [31:0]       r_fault;
    logic [7:0]        r_sample;

    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_slot;
    logic [23:0]       r_total;
    logic [SUM_W-1:0]  r_sum;
    logic              r_scale;
    logic              r_pass;
    logic [7:0]        r_adj;
    logic [18:0]       r_q;
    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]  r_rem;
    logic [DCW-1:0]    r_cnt;
    logic [1:0]        r_status;

    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [23:0]       r_out_total;
    logic [7:0]        r_out_adj;
    logic [7:0]        r_out_used;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    mqb_pkg::t_row     wr_row;

    logic [18:0]       fault_adj;
    logic [39:0]       div3_prod;
    logic [16:0]       cap_q;
    logic [16:0]       final_q;
    logic [24:0]       total_add;
    logic [SUM_W:0]    rem_sh;
    logic              rem_ge;
    logic [23:0]       score_prod;
    logic [16:0]       reg_add_pages;
    logic              id_hit;

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_status;
    assign m_tdata  = {r_out_used, r_out_adj, r_out_total};

    assign id_hit    = r_rd.active && (r_rd.id == r_id);
    assign fault_adj = (r_rd.faults > 32'(r_fthr)) ? (r_q + (r_q >> 1)) : r_q;
    assign div3_prod = 40'({fault_adj, 1'b0}) * 40'(mqb_pkg::DIV3_M);
    assign cap_q     = (r_q > 19'(r_cap)) ? r_cap : 17'(r_q);
    assign final_q   = 17'(r_q);
    assign rem_sh    = {r_rem, r_prod[PROD_W-1]};
    assign rem_ge    = (rem_sh >= {1'b0, r_sum});
    assign score_prod = 24'(r_q[11:0]) * 24'(mqb_pkg::DIV10_M);
    assign reg_add_pages = (r_state == S_REG) ? r_start : final_q;
    assign total_add = 25'(r_total) + 25'(reg_add_pages);

    // Table write port.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_row  = r_rd;
        unique case (r_state)
            S_REG: begin
                wr_en   = (r_slot < CW'(TABLE_DEPTH));
                wr_addr = r_slot[AW-1:0];
                wr_row  = '{active: 1'b1, score: mqb_pkg::INITIAL_SCORE, faults: 32'd0,
                            pages: r_start, prio: r_prio, id: r_id};
            end
            S_CHK: begin
                wr_en         = id_hit && (r_act == mqb_pkg::ACT_DEREGISTER);
                wr_row.active = 1'b0;
            end
            S_UPD2: begin
                wr_en         = 1'b1;
                wr_row.faults = r_fault;
                wr_row.score  = 8'(score_prod >> mqb_pkg::DIV10_S);
            end
            S_APPLY: begin
                wr_en        = (r_rd.pages != final_q);
                wr_row.pages = final_q;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_min       <= 14'd16;
            r_pstep     <= 7'd4;
            r_fthr      <= 16'd100;
            r_low       <= 8'd20;
            r_cap       <= 17'd8192;
            r_limit     <= 21'd65536;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    mqb_pkg::CFG_BASE_PAGES:  r_min   <= i_cfg_wdata[13:0];
                    mqb_pkg::CFG_PRIO_STEP:   r_pstep <= i_cfg_wdata[6:0];
                    mqb_pkg::CFG_FAULT_THR:   r_fthr  <= i_cfg_wdata[15:0];
                    mqb_pkg::CFG_LOW_LEVEL:   r_low   <= i_cfg_wdata[7:0];
                    mqb_pkg::CFG_ENTRY_CAP:   r_cap   <= i_cfg_wdata[16:0];
                    mqb_pkg::CFG_TOTAL_LIMIT: r_limit <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // A result loaded in S_DONE replaces the one that leaves.
            if (r_out_valid && m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_act    <= s_tuser;
                        r_id     <= s_tdata[31:0];
                        r_prio   <= s_tdata[39:32];
                        r_start  <= s_tdata[56:40];
                        r_fault  <= s_tdata[88:57];
                        r_sample <= s_tdata[96:89];
                        r_status <= mqb_pkg::ST_OK;
                        r_adj    <= '0;
                        r_idx    <= '0;
                        r_sum    <= '0;
                        r_pass   <= 1'b0;
                        unique case (s_tuser) inside
                            mqb_pkg::ACT_REGISTER:  r_state <= S_REG;
                            mqb_pkg::ACT_REBALANCE: r_state <= S_RB_RD;
                            mqb_pkg::ACT_UPDATE, mqb_pkg::ACT_DEREGISTER: begin
                                r_state <= S_SRCH;
                            end
                        endcase
                    end
                end
                S_REG: begin
                    if (r_slot < CW'(TABLE_DEPTH)) begin
                        r_slot  <= r_slot + 1'b1;
                        r_total <= (total_add > 25'(mqb_pkg::TOTAL_MAX)) ?
                                   mqb_pkg::TOTAL_MAX : 24'(total_add);
                    end else begin
                        r_status <= mqb_pkg::ST_FULL;
                    end
                    r_state <= S_DONE;
                end
                S_SRCH: begin
                    if (r_idx >= r_slot) begin
                        r_status <= mqb_pkg::ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!id_hit) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SRCH;
                    end else if (r_act == mqb_pkg::ACT_DEREGISTER) begin
                        r_total <= (r_total > 24'(r_rd.pages)) ?
                                   r_total - 24'(r_rd.pages) : 24'd0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_UPD1;
                    end
                end
                S_UPD1: begin
                    r_q     <= 19'(12'(r_rd.score) * 12'd7 + 12'(r_sample) * 12'd3);
                    r_state <= S_UPD2;
                end
                S_UPD2: begin
                    r_state <= S_DONE;
                end
                S_RB_RD: begin
                    if (r_idx >= r_slot) begin
                        if (!r_pass) begin
                            r_scale <= (CMP_W'(r_sum) > CMP_W'(r_limit));
                            r_pass  <= 1'b1;
                            r_idx   <= '0;
                            r_total <= '0;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_Q1;
                    end
                end
                S_Q1: begin
                    if (!r_rd.active) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RB_RD;
                    end else begin
                        r_q     <= 19'(15'(r_rd.prio) * 15'(r_pstep)) + 19'(r_min);
                        r_state <= S_Q2;
                    end
                end
                S_Q2: begin
                    // Raise by half on heavy faults, then cut to two thirds on low workload.
                    if (r_rd.score < r_low) begin
                        r_q <= 19'(div3_prod >> mqb_pkg::DIV3_S);
                    end else begin
                        r_q <= fault_adj;
                    end
                    r_state <= S_Q3;
                end
                S_Q3: begin
                    if (!r_pass) begin
                        r_sum   <= r_sum + SUM_W'(cap_q);
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RB_RD;
                    end else if (r_scale) begin
                        r_prod  <= PROD_W'(cap_q) * PROD_W'(r_limit);
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_q     <= 19'(cap_q);
                        r_state <= S_APPLY;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle shifted into r_prod.
                    if (rem_ge) begin
                        r_rem <= SUM_W'(rem_sh - {1'b0, r_sum});
                    end else begin
                        r_rem <= SUM_W'(rem_sh);
                    end
                    r_prod <= {r_prod[PROD_W-2:0], rem_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == DCW'(PROD_W - 1)) begin
                        r_state <= S_FLOOR;
                    end
                end
                S_FLOOR: begin
                    r_q     <= (r_prod < PROD_W'(r_min)) ? 19'(r_min) : 19'(r_prod);
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if ((r_rd.pages != final_q) && (r_adj != 8'hFF)) begin
                        r_adj <= r_adj + 1'b1;
                    end
                    r_total <= (total_add > 25'(mqb_pkg::TOTAL_MAX)) ?
                               mqb_pkg::TOTAL_MAX : 24'(total_add);
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_RB_RD;
                end
                S_DONE: begin
                    if (!r_out_valid || m_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_total  <= r_total;
                        r_out_adj    <= r_adj;
                        r_out_used   <= 8'(r_slot);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### tb/tb_memory_quota_balancer.sv
`timescale 1ns / 1ps
module tb_memory_quota_balancer;

    localparam int DEPTH = 128;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] id;
        logic [7:0]  prio;
        logic [16:0] pages;
        logic [31:0] faults;
        logic [7:0]  sample;
    } t_proc_req;

    typedef struct {
        logic [1:0]  status;
        logic [23:0] total;
        logic [7:0]  adjusted;
        logic [7:0]  used;
    } t_quota_resp;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [20:0]  i_cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic [1:0]   m_tuser;

    memory_quota_balancer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Shadow copy of the process table and configuration.
    logic [31:0] tbl_id     [DEPTH];
    logic [7:0]  tbl_prio   [DEPTH];
    logic [16:0] tbl_pages  [DEPTH];
    logic [31:0] tbl_faults [DEPTH];
    logic [7:0]  tbl_score  [DEPTH];
    logic        tbl_active [DEPTH];
    int          slots_used;
    logic [23:0] page_total;

    logic [13:0] base_pages;
    logic [6:0]  prio_step;
    logic [15:0] fault_thr;
    logic [7:0]  low_level;
    logic [16:0] entry_cap;
    logic [20:0] total_limit;

    t_proc_req   pending_reqs[$];
    t_quota_resp expected_resps[$];
    t_proc_req   cur_req;
    logic [31:0] known_ids[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int mismatches;
    int accepted_cnt;
    int result_cnt;
    int act_cnt [4];
    int status_cnt [3];
    int scaled_rebalances;

    function automatic logic [23:0] add_saturated(logic [23:0] a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > mqb_pkg::TOTAL_MAX) ? mqb_pkg::TOTAL_MAX : s[23:0];
    endfunction

    function automatic int find_entry(logic [31:0] id);
        for (int i = 0; i < slots_used; i++)
            if (tbl_active[i] && tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic longint unsigned ideal_quota_of(int i);
        longint unsigned base;
        base = base_pages + tbl_prio[i] * prio_step;
        if (tbl_faults[i] > fault_thr)
            base = (base * 3) / 2;
        if (tbl_score[i] < low_level)
            base = (base * 2) / 3;
        return (base > entry_cap) ? entry_cap : base;
    endfunction

    task automatic predict_quota_result(input t_proc_req r);
        t_quota_resp     res;
        int              k;
        longint unsigned sum;
        longint unsigned q;
        bit              scale;
        res.status   = mqb_pkg::ST_OK;
        res.adjusted = 8'd0;
        act_cnt[r.action]++;
        case (r.action)
            mqb_pkg::ACT_REGISTER: begin
                if (slots_used >= DEPTH) begin
                    res.status = mqb_pkg::ST_FULL;
                end else begin
                    tbl_id[slots_used]     = r.id;
                    tbl_prio[slots_used]   = r.prio;
                    tbl_pages[slots_used]  = r.pages;
                    tbl_faults[slots_used] = 32'd0;
                    tbl_score[slots_used]  = mqb_pkg::INITIAL_SCORE;
                    tbl_active[slots_used] = 1'b1;
                    page_total = add_saturated(page_total, r.pages);
                    slots_used++;
                end
            end
            mqb_pkg::ACT_UPDATE: begin
                k = find_entry(r.id);
                if (k < 0) begin
                    res.status = mqb_pkg::ST_NOT_FOUND;
                end else begin
                    tbl_faults[k] = r.faults;
                    tbl_score[k]  = 8'((32'(tbl_score[k]) * 7 + 32'(r.sample) * 3) / 10);
                end
            end
            mqb_pkg::ACT_DEREGISTER: begin
                k = find_entry(r.id);
                if (k < 0) begin
                    res.status = mqb_pkg::ST_NOT_FOUND;
                end else begin
                    page_total = (page_total > 24'(tbl_pages[k])) ?
                                 page_total - 24'(tbl_pages[k]) : 24'd0;
                    tbl_active[k] = 1'b0;
                end
            end
            default: begin
                sum = 0;
                for (int i = 0; i < slots_used; i++)
                    if (tbl_active[i])
                        sum += ideal_quota_of(i);
                scale = sum > total_limit;
                if (scale)
                    scaled_rebalances++;
                page_total = 24'd0;
                for (int i = 0; i < slots_used; i++) begin
                    if (tbl_active[i]) begin
                        q = ideal_quota_of(i);
                        if (scale) begin
                            q = (q * total_limit) / sum;
                            if (q < base_pages)
                                q = base_pages;
                        end
                        if (64'(tbl_pages[i]) != q) begin
                            tbl_pages[i] = q[16:0];
                            if (res.adjusted != 8'd255)
                                res.adjusted++;
                        end
                        page_total = add_saturated(page_total, q);
                    end
                end
            end
        endcase
        res.total = page_total;
        res.used  = slots_used[7:0];
        status_cnt[res.status]++;
        expected_resps.push_back(res);
    endtask

    // Driver: one item on the slave side at a time, drawn from the pending queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accepted_cnt++;
                predict_quota_result(cur_req);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.action;
                    s_tdata  <= {7'd0, cur_req.sample, cur_req.faults, cur_req.pages,
                                 cur_req.prio, cur_req.id};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_quota_resp exp_r;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                result_cnt++;
                if (expected_resps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result status=%0d data=%h", m_tuser, m_tdata);
                end else begin
                    exp_r = expected_resps.pop_front();
                    if (m_tuser !== exp_r.status || m_tdata[23:0] !== exp_r.total
                            || m_tdata[31:24] !== exp_r.adjusted
                            || m_tdata[39:32] !== exp_r.used) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: result %0d expected status=%0d total=%0d adj=%0d used=%0d",
                                     result_cnt, exp_r.status, exp_r.total, exp_r.adjusted,
                                     exp_r.used);
                            $display("       got status=%0d total=%0d adj=%0d used=%0d",
                                     m_tuser, m_tdata[23:0], m_tdata[31:24], m_tdata[39:32]);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic add_req(input logic [1:0] act, input logic [31:0] id, input logic [7:0] prio,
                           input logic [16:0] pages, input logic [31:0] faults,
                           input logic [7:0] sample);
        t_proc_req r;
        r.action = act;
        r.id     = id;
        r.prio   = prio;
        r.pages  = pages;
        r.faults = faults;
        r.sample = sample;
        pending_reqs.push_back(r);
        if (act == mqb_pkg::ACT_REGISTER)
            known_ids.push_back(id);
    endtask

    function automatic logic [31:0] pick_id();
        if (known_ids.size() > 0 && $urandom_range(99) < 85)
            return known_ids[$urandom_range(known_ids.size() - 1)];
        return $urandom;
    endfunction

    task automatic add_random_req();
        int          sel;
        logic [16:0] pg;
        logic [7:0]  pr;
        logic [31:0] ft;
        sel = $urandom_range(99);
        pg  = ($urandom_range(9) == 0) ? 17'($urandom_range(65536)) : 17'($urandom_range(600));
        pr  = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(99));
        ft  = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(300));
        if (sel < 30)
            add_req(mqb_pkg::ACT_REGISTER, ($urandom_range(9) == 0) ? pick_id() : $urandom,
                    pr, pg, $urandom, 8'($urandom));
        else if (sel < 65)
            add_req(mqb_pkg::ACT_UPDATE, pick_id(), 8'($urandom), 17'($urandom), ft,
                    8'($urandom));
        else if (sel < 85)
            add_req(mqb_pkg::ACT_DEREGISTER, pick_id(), 8'($urandom), 17'($urandom), $urandom,
                    8'($urandom));
        else
            add_req(mqb_pkg::ACT_REBALANCE, $urandom, 8'($urandom), 17'($urandom), $urandom,
                    8'($urandom));
    endtask

    task automatic write_cfg(input logic [2:0] addr, input logic [20:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            mqb_pkg::CFG_BASE_PAGES: base_pages  = val[13:0];
            mqb_pkg::CFG_PRIO_STEP:  prio_step   = val[6:0];
            mqb_pkg::CFG_FAULT_THR:  fault_thr   = val[15:0];
            mqb_pkg::CFG_LOW_LEVEL:  low_level   = val[7:0];
            mqb_pkg::CFG_ENTRY_CAP:  entry_cap   = val[16:0];
            default:                 total_limit = val;
        endcase
    endtask

    // Checked away from the rising edge so the driver and monitor have settled.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_addr         = mqb_pkg::CFG_BASE_PAGES;
        i_cfg_wdata        = '0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = mqb_pkg::ACT_REGISTER;
        m_tready           = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatches         = 0;
        accepted_cnt       = 0;
        result_cnt         = 0;
        scaled_rebalances  = 0;
        slots_used         = 0;
        page_total         = '0;
        base_pages         = 14'd16;
        prio_step          = 7'd4;
        fault_thr          = 16'd100;
        low_level          = 8'd20;
        entry_cap          = 17'd8192;
        total_limit        = 21'd65536;
        for (int i = 0; i < DEPTH; i++)
            tbl_active[i] = 1'b0;
        for (int i = 0; i < 4; i++)
            act_cnt[i] = 0;
        for (int i = 0; i < 3; i++)
            status_cnt[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset configuration.
        add_req(mqb_pkg::ACT_REBALANCE, 32'd0, 8'd0, 17'd0, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_UPDATE, 32'd7, 8'd0, 17'd0, 32'd1, 8'd1);
        add_req(mqb_pkg::ACT_DEREGISTER, 32'd7, 8'd0, 17'd0, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_REGISTER, 32'd0, 8'd0, 17'd0, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_REGISTER, 32'hFFFFFFFF, 8'hFF, 17'd65536, 32'hFFFFFFFF, 8'hFF);
        add_req(mqb_pkg::ACT_REGISTER, 32'h5A5A5A5A, 8'd99, 17'h1FFFF, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_REGISTER, 32'h5A5A5A5A, 8'd1, 17'd100, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_UPDATE, 32'hFFFFFFFF, 8'd0, 17'd0, 32'hFFFFFFFF, 8'hFF);
        add_req(mqb_pkg::ACT_UPDATE, 32'd0, 8'd0, 17'd0, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_UPDATE, 32'd0, 8'd0, 17'd0, 32'd101, 8'd0);
        add_req(mqb_pkg::ACT_UPDATE, 32'h5A5A5A5A, 8'd0, 17'd0, 32'd100, 8'd10);
        add_req(mqb_pkg::ACT_REBALANCE, 32'd0, 8'd0, 17'd0, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_REBALANCE, 32'd0, 8'd0, 17'd0, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_DEREGISTER, 32'h5A5A5A5A, 8'd0, 17'd0, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_UPDATE, 32'h5A5A5A5A, 8'd0, 17'd0, 32'd5, 8'd200);
        add_req(mqb_pkg::ACT_DEREGISTER, 32'd0, 8'd0, 17'd0, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_DEREGISTER, 32'd0, 8'd0, 17'd0, 32'd0, 8'd0);
        add_req(mqb_pkg::ACT_REBALANCE, 32'd0, 8'd0, 17'd0, 32'd0, 8'd0);
        wait_drained();

        // Phases 1 to 7 write their own configuration; the idling pattern follows the phase number modulo four.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                1: begin
                    write_cfg(mqb_pkg::CFG_TOTAL_LIMIT, 21'd1);
                    write_cfg(mqb_pkg::CFG_ENTRY_CAP, 21'd1);
                    write_cfg(mqb_pkg::CFG_BASE_PAGES, 21'd8192);
                end
                2: begin
                    write_cfg(mqb_pkg::CFG_BASE_PAGES, 21'd0);
                    write_cfg(mqb_pkg::CFG_PRIO_STEP, 21'd64);
                    write_cfg(mqb_pkg::CFG_FAULT_THR, 21'd0);
                    write_cfg(mqb_pkg::CFG_LOW_LEVEL, 21'd255);
                    write_cfg(mqb_pkg::CFG_ENTRY_CAP, 21'd65536);
                    write_cfg(mqb_pkg::CFG_TOTAL_LIMIT, 21'd1048576);
                end
                3: begin
                    write_cfg(mqb_pkg::CFG_PRIO_STEP, 21'd0);
                    write_cfg(mqb_pkg::CFG_FAULT_THR, 21'd65535);
                    write_cfg(mqb_pkg::CFG_LOW_LEVEL, 21'd0);
                    write_cfg(mqb_pkg::CFG_TOTAL_LIMIT, 21'd3000);
                end
                4, 5, 6, 7: begin
                    write_cfg(mqb_pkg::CFG_BASE_PAGES, 21'($urandom_range(300)));
                    write_cfg(mqb_pkg::CFG_PRIO_STEP, 21'($urandom_range(64)));
                    write_cfg(mqb_pkg::CFG_FAULT_THR, 21'($urandom_range(200)));
                    write_cfg(mqb_pkg::CFG_LOW_LEVEL, 21'($urandom_range(40, 60)));
                    write_cfg(mqb_pkg::CFG_ENTRY_CAP, 21'($urandom_range(1, 2000)));
                    write_cfg(mqb_pkg::CFG_TOTAL_LIMIT, 21'($urandom_range(1, 20000)));
                end
                default: ;
            endcase
            sender_idle_pct    = (ph % 4 == 1) ? 71 : (ph % 4 == 3) ? 16 : 0;
            receiver_stall_pct = (ph % 4 == 2) ? 71 : (ph % 4 == 3) ? 16 : 0;
            for (int n = 0; n < 110; n++) begin
                add_random_req();
                // In phase 5, hold the sender back once mid-phase until everything is answered.
                if (ph == 5 && n == 55)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d items (register %0d, update %0d, deregister %0d, rebalance %0d).",
                 accepted_cnt, act_cnt[0], act_cnt[1], act_cnt[2], act_cnt[3]);
        $display("Statuses ok/full/not found %0d/%0d/%0d; %0d rebalances scaled down; %0d errors.",
                 status_cnt[0], status_cnt[1], status_cnt[2], scaled_rebalances, mismatches);
        if (mismatches == 0 && expected_resps.size() == 0)
            $display("PASS memory_quota_balancer");
        else
            $display("FAIL memory_quota_balancer");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("Timeout with %0d results outstanding.", expected_resps.size());
        $display("FAIL memory_quota_balancer");
        $finish;
    end

endmodule

### sim.f
rtl/mqb_pkg.sv
rtl/memory_quota_balancer.sv
tb/tb_memory_quota_balancer.sv
